FILE: hw/rtl/gbba_pkg.sv
// Shared types and constants for the grouped bitmap block allocator.
// No dependencies.
`timescale 1ns / 1ps

package gbba_pkg;

    localparam int BLOCKS_PER_GROUP = 256;
    localparam int MAX_GROUPS       = 16;
    localparam int WORD_BITS        = 64;
    localparam int WORDS_PER_GROUP  = (BLOCKS_PER_GROUP + WORD_BITS - 1) / WORD_BITS;
    localparam int BITMAP_WORDS     = MAX_GROUPS * WORDS_PER_GROUP;
    localparam logic [12:0] TOTAL_MAX = 13'd8191;

    typedef enum logic
    {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_IGNORED = 2'd2
    } status_t;

    typedef enum logic [1:0]
    {
        REG_FIRST_DATA = 2'd0,
        REG_GROUPS     = 2'd1,
        REG_TOTAL      = 2'd2,
        REG_FREE_START = 2'd3
    } reg_idx_t;

    typedef struct packed
    {
        logic        operation;
        logic [11:0] goal_block;
        logic [11:0] block_addr;
        logic [8:0]  request_len;
    } in_req_t;

    typedef struct packed
    {
        logic [11:0] start_block;
        logic [8:0]  granted_len;
        logic [1:0]  status;
        logic [12:0] free_remaining;
    } out_res_t;

endpackage

FILE: hw/rtl/grouped_bitmap_block_allocator.sv
// Grouped bitmap block allocator: APB register file, sequencer and bitmap RAM.
// Depends on gbba_pkg and gbba_ram.
// Free checks the group and clears its bits word by word; allocate first reduces
// the goal group, then per group visited passes visit and check, clears the
// bitmap on a first visit, reads bitmap words and moves on to the next group.
// Throughput: one request at a time.
// Reset: group ready bits cleared, registers to defaults, free total 4096.
`timescale 1ns / 1ps

module grouped_bitmap_block_allocator (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  gbba_pkg::in_req_t in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output gbba_pkg::out_res_t out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    import gbba_pkg::*;

    typedef enum logic [3:0]
    {
        S_IDLE,
        S_GOAL_MOD,
        S_VISIT,
        S_PREP,
        S_CHECK,
        S_RD,
        S_DAT,
        S_NEXTG,
        S_FIN_ALLOC,
        S_FREE_START,
        S_FIN_FREE,
        S_RESULT
    } state_t;

    state_t      state_reg;
    logic        op_reg;
    logic [8:0]  req_reg;
    logic [8:0]  rem_reg;
    logic [3:0]  g_reg;
    logic [3:0]  g0_reg;
    logic [1:0]  w_reg;
    logic        run_mode_reg;
    logic [7:0]  idx_reg;
    logic [8:0]  run_reg;
    logic [8:0]  lo_reg;
    logic [8:0]  hi_reg;
    logic [8:0]  cnt_reg;
    logic        bad_reg;
    logic [MAX_GROUPS-1:0] ready_reg;
    logic [12:0] free_total_reg;
    logic [11:0] res_start_reg;
    logic [8:0]  res_len_reg;
    logic [1:0]  res_status_reg;
    logic        out_valid_reg;
    out_res_t    out_data_reg;

    logic        fdb_reg;
    logic [4:0]  groups_reg;
    logic [12:0] total_reg;
    logic [12:0] free_start_reg;

    logic [8:0]  gcnt_mem [MAX_GROUPS];

    logic        cfg_wr;
    logic [4:0]  n_eff;
    logic [8:0]  len_cur;
    logic [7:0]  tail;
    logic [8:0]  gcnt_cur;

    logic [63:0] rd_word;
    logic        ram_we;
    logic [5:0]  ram_addr;
    logic [63:0] ram_wdata;

    logic [63:0] fv;
    logic        pf_found;
    logic [5:0]  pf;
    logic [5:0]  p;
    logic [6:0]  q;
    logic [6:0]  t;
    logic [6:0]  take;
    logic [63:0] amask;
    logic [63:0] fmask;
    logic        cont;
    logic [8:0]  rem_next;

    logic [11:0] off;
    logic [8:0]  flen;
    logic [8:0]  favail;
    logic [8:0]  fcnt;
    logic [9:0]  gsum;
    logic [13:0] tsum;

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb
    begin
        case (paddr[3:2])
            REG_FIRST_DATA: prdata = {31'd0, fdb_reg};
            REG_GROUPS:     prdata = {27'd0, groups_reg};
            REG_TOTAL:      prdata = {19'd0, total_reg};
            REG_FREE_START: prdata = {19'd0, free_start_reg};
            default:        prdata = 32'd0;
        endcase
    end

    always_comb
    begin
        if (groups_reg == 5'd0)
        begin
            n_eff = 5'd1;
        end
        else if (groups_reg > 5'(MAX_GROUPS))
        begin
            n_eff = 5'(MAX_GROUPS);
        end
        else
        begin
            n_eff = groups_reg;
        end
        tail = total_reg[7:0];
        if ({1'b0, g_reg} == n_eff - 5'd1 && tail != 8'd0)
        begin
            len_cur = {1'b0, tail};
        end
        else
        begin
            len_cur = 9'(BLOCKS_PER_GROUP);
        end
        gcnt_cur = gcnt_mem[g_reg];
    end

    // word scan
    always_comb
    begin
        for (int b = 0; b < 64; b++)
        begin
            fv[b] = !rd_word[b] && ({1'b0, w_reg, 6'(b)} < len_cur);
        end
        pf_found = |fv;
        pf = 6'd0;
        for (int b = 63; b >= 0; b--)
        begin
            if (fv[b])
            begin
                pf = 6'(b);
            end
        end
        p = run_mode_reg ? 6'd0 : pf;
        q = 7'd64;
        for (int b = 63; b >= 0; b--)
        begin
            if (6'(b) >= p && !fv[b])
            begin
                q = 7'(b);
            end
        end
        t = q - {1'b0, p};
        take = (rem_reg < {2'b0, t}) ? rem_reg[6:0] : t;
        for (int b = 0; b < 64; b++)
        begin
            amask[b] = (7'(b) >= {1'b0, p}) && (7'(b) < {1'b0, p} + take);
            fmask[b] = ({1'b0, w_reg, 6'(b)} >= lo_reg) && ({1'b0, w_reg, 6'(b)} < hi_reg);
        end
        rem_next = rem_reg - {2'b0, take};
        cont = ({1'b0, p} + t == 7'd64) && (take == t) && (rem_next != 9'd0)
            && (w_reg != 2'(WORDS_PER_GROUP - 1));
    end

    // free range setup
    always_comb
    begin
        off = in_data.block_addr - {11'd0, fdb_reg};
        flen = len_cur;
        favail = flen - lo_reg;
        if (lo_reg < flen)
        begin
            fcnt = (favail < req_reg) ? favail : req_reg;
        end
        else
        begin
            fcnt = 9'd0;
        end
        gsum = {1'b0, gcnt_cur} + {1'b0, cnt_reg};
        tsum = {1'b0, free_total_reg} + {5'd0, cnt_reg};
    end

    always_comb
    begin
        ram_addr = {g_reg, w_reg};
        ram_we = 1'b0;
        ram_wdata = 64'd0;
        case (state_reg)
            S_PREP:
            begin
                ram_we = 1'b1;
            end
            S_DAT:
            begin
                if (op_reg == OP_FREE)
                begin
                    ram_we = 1'b1;
                    ram_wdata = rd_word & ~fmask;
                end
                else if (run_mode_reg || pf_found)
                begin
                    ram_we = 1'b1;
                    ram_wdata = rd_word | amask;
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    gbba_ram #(
        .WIDTH(WORD_BITS),
        .DEPTH(BITMAP_WORDS)
    ) u_bitmap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (ram_wdata),
        .raddr (ram_addr),
        .rdata (rd_word)
    );

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_PREP:
            begin
                if (w_reg == 2'(WORDS_PER_GROUP - 1))
                begin
                    gcnt_mem[g_reg] <= len_cur;
                end
            end
            S_DAT:
            begin
                if (op_reg == OP_ALLOC && !run_mode_reg && !pf_found
                    && w_reg == 2'(WORDS_PER_GROUP - 1))
                begin
                    gcnt_mem[g_reg] <= 9'd0;
                end
            end
            S_FIN_ALLOC:
            begin
                gcnt_mem[g_reg] <= (gcnt_cur > run_reg) ? gcnt_cur - run_reg : 9'd0;
            end
            S_FIN_FREE:
            begin
                gcnt_mem[g_reg] <= (gsum > {1'b0, len_cur}) ? len_cur : gsum[8:0];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ready_reg      <= '0;
            free_total_reg <= 13'd4096;
            fdb_reg        <= 1'b0;
            groups_reg     <= 5'd16;
            total_reg      <= 13'd4096;
            free_start_reg <= 13'd4096;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
            op_reg         <= 1'b0;
            req_reg        <= '0;
            rem_reg        <= '0;
            g_reg          <= '0;
            g0_reg         <= '0;
            w_reg          <= '0;
            run_mode_reg   <= 1'b0;
            idx_reg        <= '0;
            run_reg        <= '0;
            lo_reg         <= '0;
            hi_reg         <= '0;
            cnt_reg        <= '0;
            bad_reg        <= 1'b0;
            res_start_reg  <= '0;
            res_len_reg    <= '0;
            res_status_reg <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && state_reg != S_RESULT)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr)
            begin
                case (paddr[3:2])
                    REG_FIRST_DATA: fdb_reg <= pwdata[0];
                    REG_GROUPS:     groups_reg <= pwdata[4:0];
                    REG_TOTAL:      total_reg <= pwdata[12:0];
                    REG_FREE_START:
                    begin
                        free_start_reg <= pwdata[12:0];
                        free_total_reg <= pwdata[12:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg  <= in_data.operation;
                        req_reg <= in_data.request_len;
                        rem_reg <= in_data.request_len;
                        run_reg <= 9'd0;
                        w_reg   <= 2'd0;
                        if (in_data.operation == OP_ALLOC)
                        begin
                            if (in_data.goal_block == 12'd0)
                            begin
                                g_reg <= 4'd0;
                            end
                            else
                            begin
                                g_reg <= 4'((in_data.goal_block - {11'd0, fdb_reg}) >> 8);
                            end
                            state_reg <= S_GOAL_MOD;
                        end
                        else
                        begin
                            bad_reg   <= in_data.block_addr < {11'd0, fdb_reg};
                            g_reg     <= off[11:8];
                            lo_reg    <= {1'b0, off[7:0]};
                            state_reg <= S_FREE_START;
                        end
                    end
                end
                S_GOAL_MOD:
                begin
                    if ({1'b0, g_reg} >= n_eff)
                    begin
                        g_reg <= 4'({1'b0, g_reg} - n_eff);
                    end
                    else
                    begin
                        g0_reg    <= g_reg;
                        state_reg <= S_VISIT;
                    end
                end
                S_VISIT:
                begin
                    w_reg <= 2'd0;
                    state_reg <= ready_reg[g_reg] ? S_CHECK : S_PREP;
                end
                S_PREP:
                begin
                    w_reg <= w_reg + 2'd1;
                    if (w_reg == 2'(WORDS_PER_GROUP - 1))
                    begin
                        ready_reg[g_reg] <= 1'b1;
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    w_reg        <= 2'd0;
                    run_mode_reg <= 1'b0;
                    state_reg    <= (gcnt_cur != 9'd0) ? S_RD : S_NEXTG;
                end
                S_RD:
                begin
                    state_reg <= S_DAT;
                end
                S_DAT:
                begin
                    if (op_reg == OP_FREE)
                    begin
                        if (w_reg == 2'(WORDS_PER_GROUP - 1)
                            || {1'b0, w_reg + 2'd1, 6'd0} >= hi_reg)
                        begin
                            state_reg <= S_FIN_FREE;
                        end
                        else
                        begin
                            w_reg     <= w_reg + 2'd1;
                            state_reg <= S_RD;
                        end
                    end
                    else if (!run_mode_reg && !pf_found)
                    begin
                        if (w_reg == 2'(WORDS_PER_GROUP - 1))
                        begin
                            state_reg <= S_NEXTG;
                        end
                        else
                        begin
                            w_reg     <= w_reg + 2'd1;
                            state_reg <= S_RD;
                        end
                    end
                    else
                    begin
                        if (!run_mode_reg)
                        begin
                            idx_reg <= {w_reg, pf};
                        end
                        run_reg <= run_reg + {2'b0, take};
                        rem_reg <= rem_next;
                        if (cont)
                        begin
                            run_mode_reg <= 1'b1;
                            w_reg        <= w_reg + 2'd1;
                            state_reg    <= S_RD;
                        end
                        else
                        begin
                            state_reg <= S_FIN_ALLOC;
                        end
                    end
                end
                S_NEXTG:
                begin
                    if ({1'b0, g_reg} + 5'd1 == n_eff)
                    begin
                        g_reg <= 4'd0;
                    end
                    else
                    begin
                        g_reg <= g_reg + 4'd1;
                    end
                    if ((({1'b0, g_reg} + 5'd1 == n_eff) ? 4'd0 : g_reg + 4'd1) == g0_reg)
                    begin
                        res_start_reg  <= 12'd0;
                        res_len_reg    <= 9'd0;
                        res_status_reg <= ST_NOSPACE;
                        state_reg      <= S_RESULT;
                    end
                    else
                    begin
                        state_reg <= S_VISIT;
                    end
                end
                S_FIN_ALLOC:
                begin
                    free_total_reg <= (free_total_reg > {4'd0, run_reg})
                        ? free_total_reg - {4'd0, run_reg} : 13'd0;
                    res_start_reg  <= {g_reg, idx_reg} + {11'd0, fdb_reg};
                    res_len_reg    <= run_reg;
                    res_status_reg <= ST_OK;
                    state_reg      <= S_RESULT;
                end
                S_FREE_START:
                begin
                    if (bad_reg || !ready_reg[g_reg])
                    begin
                        res_start_reg  <= 12'd0;
                        res_len_reg    <= 9'd0;
                        res_status_reg <= ST_IGNORED;
                        state_reg      <= S_RESULT;
                    end
                    else
                    begin
                        cnt_reg <= fcnt;
                        hi_reg  <= lo_reg + fcnt;
                        w_reg   <= lo_reg[7:6];
                        state_reg <= (fcnt == 9'd0) ? S_FIN_FREE : S_RD;
                    end
                end
                S_FIN_FREE:
                begin
                    free_total_reg <= (tsum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : tsum[12:0];
                    res_start_reg  <= 12'd0;
                    res_len_reg    <= cnt_reg;
                    res_status_reg <= ST_OK;
                    state_reg      <= S_RESULT;
                end
                S_RESULT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg                <= 1'b1;
                        out_data_reg.start_block     <= res_start_reg;
                        out_data_reg.granted_len     <= res_len_reg;
                        out_data_reg.status          <= res_status_reg;
                        out_data_reg.free_remaining  <= free_total_reg;
                        state_reg                    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: hw/rtl/gbba_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module gbba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
